// File: src/lladh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lladh_pkg
// Shared constants, types and the threshold mapping for the light level
// averager with debounce and hysteresis.
// ----------------------------------------------------------------------------
package lladh_pkg;

  localparam int SAMPLE_W          = 15;
  localparam int PERCENT_W         = 8;
  localparam int AVERAGE_SHIFT     = 6;
  localparam int DEBOUNCE_LIMIT    = 3;
  localparam int HYSTERESIS_MARGIN = 5;

  localparam int BLOCK_LEN = 1 << AVERAGE_SHIFT;
  localparam int SUM_W     = SAMPLE_W + AVERAGE_SHIFT;
  localparam int CNT_W     = AVERAGE_SHIFT + 1;
  localparam int DIFF_W    = (DEBOUNCE_LIMIT + 1 < 2) ? 1 : $clog2(DEBOUNCE_LIMIT + 2);
  localparam int THR_W     = 12;
  localparam int CMP_W     = SAMPLE_W + 1;
  localparam int DIVP_W    = 7;

  localparam logic [PERCENT_W-1:0] PERCENT_FULL  = 8'd100;
  localparam logic [PERCENT_W-1:0] PERCENT_RESET = 8'd70;
  localparam logic [THR_W-1:0]     PERCENT_STEP  = 12'd29;

  // One block word from the accumulator to the evaluator.
  typedef struct packed {
    logic                eval;
    logic [SAMPLE_W-1:0] avg;
  } blk_t;

  // Post-evaluation state reported for each word.
  typedef struct packed {
    logic                dark;
    logic [SAMPLE_W-1:0] level;
  } res_t;

  // Percent register to level threshold; percentages above full scale give 0.
  function automatic logic [THR_W-1:0] level_threshold(input logic [PERCENT_W-1:0] p);
    logic [DIVP_W-1:0] rem;
    logic [THR_W-1:0]  prod;
    rem  = DIVP_W'(PERCENT_FULL - p);
    prod = {{(THR_W-DIVP_W){1'b0}}, rem} * PERCENT_STEP;
    if (p > PERCENT_FULL) begin
      return '0;
    end
    return prod;
  endfunction

endpackage
`default_nettype wire

// File: src/lladh_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lladh_accum
// Sums done samples in blocks and flags the done word that closes a block.
// ----------------------------------------------------------------------------
module lladh_accum
  import lladh_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic                done,
  input  wire logic [SAMPLE_W-1:0] sample,
  output blk_t                     blk
);

  logic [SUM_W-1:0] sample_sum;
  logic [CNT_W-1:0] sample_count;
  logic             full;

  assign full     = (sample_count == CNT_W'(BLOCK_LEN));
  assign blk.eval = step && done && full;
  assign blk.avg  = sample_sum[SUM_W-1:AVERAGE_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (step && done) begin
      if (full) begin
        // The closing word's own sample is dropped.
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sample_sum + {{AVERAGE_SHIFT{1'b0}}, sample};
        sample_count <= sample_count + CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(BLOCK_LEN))
    else $error("sample count passed the block length");

  a_clear_after_eval: assert property (@(posedge clk) disable iff (rst)
    blk.eval |=> (sample_count == '0) && (sample_sum == '0))
    else $error("block not cleared after evaluation");

endmodule
`default_nettype wire

// File: src/lladh_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lladh_eval
// Debounces block averages into the held level and drives the dark flag
// with hysteresis around the configured threshold.
// ----------------------------------------------------------------------------
module lladh_eval
  import lladh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [PERCENT_W-1:0] cfg_wdata,
  input  wire blk_t                 blk,
  output res_t                      res_next
);

  logic [PERCENT_W-1:0] threshold_percent;
  logic [DIFF_W-1:0]    differ_count;
  logic [DIFF_W-1:0]    differ_count_next;
  logic [SAMPLE_W-1:0]  level_hold;
  logic [SAMPLE_W-1:0]  level_hold_next;
  logic                 dark_state;
  logic                 dark_state_next;
  logic [THR_W-1:0]     thr;
  logic [CMP_W-1:0]     thr_hi;

  assign thr    = level_threshold(threshold_percent);
  assign thr_hi = CMP_W'(thr) + CMP_W'(HYSTERESIS_MARGIN);

  always_comb begin
    differ_count_next = differ_count;
    level_hold_next   = level_hold;
    dark_state_next   = dark_state;
    if (blk.eval) begin
      priority if (blk.avg == level_hold) begin
        differ_count_next = '0;
      end else if (differ_count > DIFF_W'(DEBOUNCE_LIMIT)) begin
        level_hold_next   = blk.avg;
        differ_count_next = '0;
      end else begin
        differ_count_next = differ_count + DIFF_W'(1);
      end
      // The flag follows the level as it stands after the debounce step.
      if (!dark_state) begin
        dark_state_next = ({1'b0, level_hold_next} > thr_hi);
      end else begin
        dark_state_next = !({1'b0, level_hold_next} < CMP_W'(thr));
      end
    end
  end

  assign res_next.dark  = dark_state_next;
  assign res_next.level = level_hold_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_percent <= PERCENT_RESET;
      differ_count      <= '0;
      level_hold        <= '0;
      dark_state        <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold_percent <= cfg_wdata;
      end
      differ_count <= differ_count_next;
      level_hold   <= level_hold_next;
      dark_state   <= dark_state_next;
    end
  end

  a_differ_bound: assert property (@(posedge clk) disable iff (rst)
    differ_count <= DIFF_W'(DEBOUNCE_LIMIT + 1))
    else $error("differ count passed the debounce limit");

  a_hold_only_on_eval: assert property (@(posedge clk) disable iff (rst)
    !blk.eval |=> $stable(level_hold) && $stable(dark_state))
    else $error("held state moved without an evaluation");

endmodule
`default_nettype wire

// File: src/light_level_average_debounce_hysteresis.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// light_level_average_debounce_hysteresis
// Averages light-sensor ADC words in blocks, debounces the averages into a
// held level and reports a dark flag with hysteresis.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    conversion_done, sample_value
//   out      out_valid/out_ready  dark_flag, held_level, average_done
//   cfg      cfg_we               cfg_wdata (threshold percent)
//
// One word is accepted per cycle while out is not stalled; it passes from the
// input register to the result register, where its result is offered on out.
// State is updated as a word leaves the input register, so words can follow
// back to back. A stall on out holds both registers, and in_ready drops only
// when both are occupied. Reset clears the valid flags and the block and
// debounce state, not the data registers; the threshold returns to 70 percent.
// ----------------------------------------------------------------------------
module light_level_average_debounce_hysteresis
  import lladh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 conversion_done,
  input  wire logic [SAMPLE_W-1:0]  sample_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      dark_flag,
  output logic [SAMPLE_W-1:0]       held_level,
  output logic                      average_done,
  input  wire logic                 cfg_we,
  input  wire logic [PERCENT_W-1:0] cfg_wdata
);

  logic                s1_valid;
  logic                s1_done;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                advance;
  logic                step;
  blk_t                blk;
  res_t                res_next;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_done   <= conversion_done;
      s1_sample <= sample_value;
    end
  end

  lladh_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .done   (s1_done),
    .sample (s1_sample),
    .blk    (blk)
  );

  lladh_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .blk       (blk),
    .res_next  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      dark_flag    <= res_next.dark;
      held_level   <= res_next.level;
      average_done <= blk.eval;
    end
  end

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid || !out_valid) |-> in_ready)
    else $error("input stalled with a free register");

  a_word_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> out_valid)
    else $error("word lost between the input and result registers");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light level averager testbench
// Drives ADC words through the valid/ready input with random gaps, predicts
// the block average, debounced held level and dark flag for every word, and
// checks each result word in order while the output side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
  import lladh_pkg::*;

  localparam int WATCHDOG_LIMIT = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic                dark;
    logic [SAMPLE_W-1:0] level;
    logic                avg_done;
  } light_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 conversion_done = 1'b0;
  logic [SAMPLE_W-1:0]  sample_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 dark_flag;
  logic [SAMPLE_W-1:0]  held_level;
  logic                 average_done;
  logic                 cfg_we = 1'b0;
  logic [PERCENT_W-1:0] cfg_wdata = '0;

  // Predicted block state and threshold setting.
  int unsigned          acc_sum = 0;
  int unsigned          acc_count = 0;
  int unsigned          miss_run = 0;
  logic [SAMPLE_W-1:0]  kept_level = '0;
  logic                 is_dark = 1'b0;
  logic [PERCENT_W-1:0] percent = PERCENT_RESET;

  light_result_t expected_readings[$];
  light_result_t last_reading;

  bit word_offered = 1'b0;
  bit fast_in = 1'b0;
  bit fast_out = 1'b0;
  int ready_hold = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int blocks_closed = 0;
  int hold_changes = 0;
  int dark_changes = 0;
  int settings_used = 0;

  light_level_average_debounce_hysteresis DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .conversion_done (conversion_done),
    .sample_value    (sample_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .dark_flag       (dark_flag),
    .held_level      (held_level),
    .average_done    (average_done),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int draw_wait(input bit fast);
    if (fast || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic int unsigned dark_threshold(input logic [PERCENT_W-1:0] p);
    if (p > PERCENT_FULL) return 0;
    return (int'(PERCENT_FULL) - int'(p)) * int'(PERCENT_STEP);
  endfunction

  function automatic light_result_t predict_reading(input logic done,
                                                    input logic [SAMPLE_W-1:0] sample);
    logic [SAMPLE_W-1:0] avg;
    int unsigned         thr;
    light_result_t       r;
    r.avg_done = 1'b0;
    if (done) begin
      if (acc_count < BLOCK_LEN) begin
        acc_sum += sample;
        acc_count++;
      end else begin
        // The word after a full block is dropped and closes the block.
        avg = SAMPLE_W'(acc_sum >> AVERAGE_SHIFT);
        thr = dark_threshold(percent);
        acc_sum = 0;
        acc_count = 0;
        blocks_closed++;
        if (avg == kept_level) begin
          miss_run = 0;
        end else if (miss_run > DEBOUNCE_LIMIT) begin
          kept_level = avg;
          miss_run = 0;
          hold_changes++;
        end else begin
          miss_run++;
        end
        if (!is_dark && kept_level > thr + HYSTERESIS_MARGIN) begin
          is_dark = 1'b1;
          dark_changes++;
        end else if (is_dark && kept_level < thr) begin
          is_dark = 1'b0;
          dark_changes++;
        end
        r.avg_done = 1'b1;
      end
    end
    r.dark = is_dark;
    r.level = kept_level;
    return r;
  endfunction

  // Offers one word after a random gap and records its expected result.
  task automatic send_word(input logic done, input logic [SAMPLE_W-1:0] sample);
    int gap;
    gap = draw_wait(fast_in);
    if (gap > 0) begin
      if (word_offered) begin
        in_valid <= 1'b0;
        word_offered = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    conversion_done <= done;
    sample_value <= sample;
    word_offered = 1'b1;
    do @(posedge clk); while (!in_ready);
    last_reading = predict_reading(done, sample);
    expected_readings.push_back(last_reading);
    words_sent++;
  endtask

  // Lowers valid and waits until every expected result has been taken.
  task automatic drain();
    if (word_offered) begin
      in_valid <= 1'b0;
      word_offered = 1'b0;
    end
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_percent(input logic [PERCENT_W-1:0] p);
    cfg_wdata <= p;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    percent = p;
    settings_used++;
  endtask

  // Sends words around one level until a block closes; idle reads are mixed in.
  task automatic run_block(input logic [SAMPLE_W-1:0] level, input int spread);
    logic        done;
    int unsigned s;
    bit          closed;
    closed = 1'b0;
    fast_in = ($urandom_range(0, 3) == 0);
    fast_out = ($urandom_range(0, 3) == 0);
    while (!closed) begin
      done = ($urandom_range(0, 15) != 0);
      s = level + $urandom_range(0, spread);
      if (s > 'h7FFF) s = 'h7FFF;
      if (!done) s = $urandom_range(0, 'h7FFF);
      send_word(done, SAMPLE_W'(s));
      closed = last_reading.avg_done;
    end
    fast_in = 1'b0;
    fast_out = 1'b0;
  endtask

  task automatic test_field_extremes();
    logic [SAMPLE_W:0] word_list [14] = '{
      {1'b0, 15'h0000}, {1'b0, 15'h7FFF}, {1'b1, 15'h0000}, {1'b1, 15'h7FFF},
      {1'b1, 15'h5555}, {1'b1, 15'h2AAA}, {1'b0, 15'h5555}, {1'b0, 15'h2AAA},
      {1'b1, 15'h4000}, {1'b1, 15'h0001}, {1'b0, 15'h0000}, {1'b1, 15'h7FFE},
      {1'b1, 15'h7FFF}, {1'b0, 15'h7FFF}};
    foreach (word_list[i]) begin
      // Second half runs back to back with the output side stalling.
      fast_in = (i >= 7);
      send_word(word_list[i][SAMPLE_W], word_list[i][SAMPLE_W-1:0]);
    end
    fast_in = 1'b0;
  endtask

  // Five differing averages in a row move the held level into the band.
  task automatic test_debounce_take();
    logic [SAMPLE_W-1:0] band_level;
    band_level = SAMPLE_W'(dark_threshold(PERCENT_RESET) + 2);
    repeat (4) run_block(band_level, 0);
    // The fifth is taken; inside the band the flag stays bright.
    run_block(band_level, 0);
  endtask

  task automatic test_threshold_hysteresis();
    logic [SAMPLE_W-1:0] held;
    logic [SAMPLE_W-1:0] other;
    held = kept_level;
    do other = SAMPLE_W'($urandom_range(0, 'h7FFF)); while (other == held);
    // Above full scale the threshold is zero, so the held level sets dark.
    drain();
    write_percent(8'd101);
    run_block(other, 0);
    // Back in the band the flag holds dark, and an equal average restarts
    // the count of differing ones.
    drain();
    write_percent(PERCENT_RESET);
    run_block(held, 0);
  endtask

  // One block of widely spread samples with the threshold above the held level.
  task automatic test_random_block();
    logic [SAMPLE_W-1:0] base;
    base = SAMPLE_W'($urandom_range(0, 'h7FFF));
    drain();
    write_percent(8'd69);
    run_block(base, $urandom_range(1, 'h7FFF));
  endtask

  // Result side: random stall per result, in-order comparison.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("Result word %0d arrived with nothing outstanding", results_checked);
        end else begin
          last_check: begin
            light_result_t e;
            e = expected_readings.pop_front();
            if (dark_flag !== e.dark || held_level !== e.level ||
                average_done !== e.avg_done) begin
              fail_count++;
              if (fail_count <= MAX_REPORTS)
                $display("Result %0d: expected dark/level/done %0b/%0d/%0b, got %0b/%0d/%0b",
                         results_checked, e.dark, e.level, e.avg_done,
                         dark_flag, held_level, average_done);
            end
          end
        end
        ready_hold = draw_wait(fast_out);
      end
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_debounce_take();
    test_threshold_hysteresis();
    test_random_block();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words, checked %0d results, %0d blocks, %0d threshold writes.",
             words_sent, results_checked, blocks_closed, settings_used);
    $display("The held level moved %0d times and the dark flag changed %0d times.",
             hold_changes, dark_changes);
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/lladh_pkg.sv
src/lladh_accum.sv
src/lladh_eval.sv
src/light_level_average_debounce_hysteresis.sv
tb/sv/testbench.sv
